FILE: design/drt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difficulty retarget package
// Widths, register indexes, reset values, the divider request word and the
// sequencer states shared by the retarget block and its serial units.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Field widths.
    localparam int TIME_W   = 40;
    localparam int TARGET_W = 64;
    localparam int IDEAL_W  = 16;
    localparam int TEMPER_W = 8;
    localparam int COUNT_W  = 6;
    localparam int CFG_IDX_W = 2;

    // Fixed-point span arithmetic: 8 fractional bits.
    localparam int FRAC_W  = 8;
    localparam int SPAN_W  = 32;               // ideal span, bounds and goal
    localparam int DIFF_W  = TIME_W + 1;       // signed timestamp difference
    localparam int DEV_W   = DIFF_W + FRAC_W + 1; // signed span deviation
    localparam int GOAL_W  = DEV_W + 2;        // signed unclamped goal
    localparam int P100_W  = SPAN_W + 7;       // ideal span times 100
    localparam int PROD_W  = TARGET_W + SPAN_W; // target times goal

    // Serial unit step counters.
    localparam int DIV_CNT_W = 7;
    localparam int MUL_CNT_W = 6;

    // Clamp ratio constants.
    localparam int SCALE_NUM = 100;
    localparam int LO_DEN    = 116;
    localparam int HI_DEN    = 68;

    // Block counter saturates here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IDEAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 2'd2;

    // Configuration reset values.
    localparam logic [IDEAL_W-1:0]  IDEAL_RESET   = 16'd75;
    localparam logic [TEMPER_W-1:0] TEMPER_RESET  = 8'd32;
    localparam logic [TARGET_W-1:0] INITIAL_RESET = 64'h0001_0000_0000_0000;

    // Request to the serial divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    // Retarget sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_DEV,
        ST_MAG_GO,
        ST_MAG_WAIT,
        ST_LO_GO,
        ST_LO_WAIT,
        ST_HI_GO,
        ST_HI_WAIT,
        ST_GOAL,
        ST_CLAMP,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_QUO_GO,
        ST_QUO_WAIT,
        ST_FINISH
    } state_t;

endpackage

FILE: design/drt_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp history
// Shift line of the last WINDOW+1 block timestamps, newest first, and a
// saturating count of blocks seen.
// ----------------------------------------------------------------------------
module drt_hist #(
    parameter int WINDOW = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [drt_pkg::TIME_W-1:0]  now,
    output logic [drt_pkg::TIME_W-1:0]  prev,
    output logic [drt_pkg::TIME_W-1:0]  oldest,
    output logic                        full
);

    localparam int DEPTH = WINDOW + 1;

    logic [drt_pkg::TIME_W-1:0]  times_reg [DEPTH];
    logic [drt_pkg::COUNT_W-1:0] count_reg;
    logic [drt_pkg::COUNT_W-1:0] count_next;

    // Timestamps move one place down on every push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            times_reg[0] <= now;
            for (int i = 1; i < DEPTH; i++)
            begin
                times_reg[i] <= times_reg[i-1];
            end
        end
    end

    // Block count stops at its maximum.
    always_comb
    begin
        count_next = count_reg;
        if (push && (count_reg != drt_pkg::COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prev   = times_reg[0];
    assign oldest = times_reg[WINDOW];
    assign full   = (count_reg > drt_pkg::COUNT_W'(WINDOW));

endmodule

FILE: design/drt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that retires one quotient bit per cycle. The dividend is
// loaded left-aligned and the quotient collects in the low bits.
// ----------------------------------------------------------------------------
module drt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  drt_pkg::div_req_t           req,
    input  logic [drt_pkg::PROD_W-1:0]  dividend,
    input  logic [drt_pkg::SPAN_W-1:0]  divisor,
    output logic                        done,
    output logic [drt_pkg::PROD_W-1:0]  quotient
);

    localparam int PW = drt_pkg::PROD_W;
    localparam int SW = drt_pkg::SPAN_W;

    logic [PW-1:0]                 dvd_reg;
    logic [SW-1:0]                 rem_reg;
    logic [drt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [SW+1:0] trial;
    logic          qbit;
    logic [SW-1:0] rem_step;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial    = {1'b0, rem_reg, dvd_reg[PW-1]} - {2'b00, divisor};
        qbit     = ~trial[SW+1];
        rem_step = qbit ? trial[SW-1:0] : {rem_reg[SW-2:0], dvd_reg[PW-1]};
    end

    // Payload shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[PW-2:0], qbit};
            rem_reg <= rem_step;
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == drt_pkg::DIV_CNT_W'(1));
            if (req.start)
            begin
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != drt_pkg::DIV_CNT_W'(1));
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    // A new division is only started once the previous one has finished.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    // The partial remainder stays below the divisor throughout.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < divisor))
        else $error("divider remainder out of range");

    // The last step is followed by exactly one done pulse.
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (cnt_reg == drt_pkg::DIV_CNT_W'(1)) && !req.start)
        |=> (done_reg && !busy_reg))
        else $error("divider done pulse missing");

endmodule

FILE: design/drt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiplier that consumes one multiplier bit per cycle, low
// bit first, giving the full 96-bit product of target and goal span.
// ----------------------------------------------------------------------------
module drt_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [drt_pkg::TARGET_W-1:0]  multiplicand,
    input  logic [drt_pkg::SPAN_W-1:0]    multiplier,
    output logic                          done,
    output logic [drt_pkg::PROD_W-1:0]    product
);

    localparam int TW = drt_pkg::TARGET_W;
    localparam int SW = drt_pkg::SPAN_W;

    logic [TW-1:0]                 hi_reg;
    logic [SW-1:0]                 lo_reg;
    logic [drt_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [TW:0] sum;

    // Add the multiplicand when the current multiplier bit is set.
    always_comb
    begin
        sum = {1'b0, hi_reg};
        if (lo_reg[0])
        begin
            sum = {1'b0, hi_reg} + {1'b0, multiplicand};
        end
    end

    // Partial product shifts right one place per step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= multiplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[TW:1];
            lo_reg <= {sum[0], lo_reg[SW-1:1]};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == drt_pkg::MUL_CNT_W'(1));
            if (start)
            begin
                cnt_reg  <= drt_pkg::MUL_CNT_W'(SW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != drt_pkg::MUL_CNT_W'(1));
            end
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

    // A new product is only started once the previous one has finished.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    // The multiplicand holds still while the product is being built.
    a_mcand_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && $past(busy_reg)) |-> $stable(multiplicand))
        else $error("multiplicand changed during multiply");

    // Done only follows a running multiply.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("multiplier done without a multiply");

endmodule

FILE: design/block_difficulty_retarget.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block difficulty retarget
// Computes the target for the next block from a window of block timestamps,
// damping the span deviation and clamping the goal span before scaling.
// ----------------------------------------------------------------------------
// Each accepted block timestamp gives exactly one result word. While no more
// than WINDOW blocks have been seen the result is the live initial_target
// register. Once the window is full the target is retargeted with a
// bit-serial divider and a bit-serial multiplier, one bit per cycle: the
// damping divide (50 steps), the two clamp bounds (39 steps each) and the
// final 96-step quotient run one after another through the one shared
// divider, and the target-times-goal multiply (32 steps) runs in the
// multiplier between the bounds and the quotient. The next word is taken the
// cycle after a result is registered, even if that result is still stalled
// at the output. Configuration writes are always taken and must only be made
// while no block is in flight.
module block_difficulty_retarget #(
    parameter int WINDOW = 17
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Block timestamp channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [drt_pkg::TIME_W-1:0]      block_stamp,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [drt_pkg::TARGET_W-1:0]    next_target,
    output logic                            window_full,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [drt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [drt_pkg::TARGET_W-1:0]    cfg_data
);

    localparam int TW      = drt_pkg::TARGET_W;
    localparam int SW      = drt_pkg::SPAN_W;
    localparam int PW      = drt_pkg::PROD_W;
    localparam int WPROD_W = SW - drt_pkg::FRAC_W;

    // Configuration registers.
    logic [drt_pkg::IDEAL_W-1:0]  ideal_reg;
    logic [drt_pkg::TEMPER_W-1:0] temper_reg;
    logic [TW-1:0]                initial_reg;

    // Sequencer and result state.
    drt_pkg::state_t state_reg;
    drt_pkg::state_t state_next;
    logic            full_reg;
    logic            out_valid_reg;
    logic            out_full_reg;
    logic [TW-1:0]   current_target_reg;

    // Retarget datapath.
    logic [drt_pkg::TIME_W-1:0] now_reg;
    logic [SW-1:0]              ispan_reg;
    logic [drt_pkg::DIFF_W-1:0] diff_reg;
    logic [drt_pkg::DEV_W-1:0]  dev_reg;
    logic [drt_pkg::P100_W-1:0] p100_reg;
    logic [drt_pkg::DEV_W-1:0]  step_reg;
    logic [SW-1:0]              lo_reg;
    logic [SW-1:0]              hi_reg;
    logic [drt_pkg::GOAL_W-1:0] goal_raw_reg;
    logic [SW-1:0]              goal_reg;

    // Unit connections.
    logic [drt_pkg::TIME_W-1:0] hist_prev;
    logic [drt_pkg::TIME_W-1:0] hist_oldest;
    logic                       hist_full;
    logic                       hist_push;
    drt_pkg::div_req_t          div_req;
    logic [PW-1:0]              div_dividend;
    logic [SW-1:0]              div_divisor;
    logic                       div_done;
    logic [PW-1:0]              div_quo;
    logic                       mul_start;
    logic                       mul_done;
    logic [PW-1:0]              mul_prod;

    // Derived values.
    logic [drt_pkg::IDEAL_W-1:0]  ideal_eff;
    logic [drt_pkg::TEMPER_W-1:0] temper_eff;
    logic [WPROD_W-1:0]           win_prod;
    logic [drt_pkg::DEV_W-1:0]    dev_mag;
    logic [drt_pkg::GOAL_W-1:0]   ispan_ext;
    logic [drt_pkg::GOAL_W-1:0]   step_ext;
    logic [drt_pkg::GOAL_W-1:0]   lo_ext;
    logic [drt_pkg::GOAL_W-1:0]   hi_ext;
    logic [TW-1:0]                sat_target;
    logic                         in_accept;
    logic                         out_free;
    logic                         finish_go;

    // ------------------------------------------------------------------------
    // Units
    // ------------------------------------------------------------------------
    drt_hist #(
        .WINDOW (WINDOW)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (hist_push),
        .now    (now_reg),
        .prev   (hist_prev),
        .oldest (hist_oldest),
        .full   (hist_full)
    );

    drt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    drt_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (current_target_reg),
        .multiplier   (goal_reg),
        .done         (mul_done),
        .product      (mul_prod)
    );

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ideal_reg   <= drt_pkg::IDEAL_RESET;
            temper_reg  <= drt_pkg::TEMPER_RESET;
            initial_reg <= drt_pkg::INITIAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                drt_pkg::REG_IDEAL:   ideal_reg   <= cfg_data[drt_pkg::IDEAL_W-1:0];
                drt_pkg::REG_TEMPER:  temper_reg  <= cfg_data[drt_pkg::TEMPER_W-1:0];
                drt_pkg::REG_INITIAL: initial_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // A zero ideal time or damping divisor counts as one.
    assign ideal_eff  = (ideal_reg == '0) ? drt_pkg::IDEAL_W'(1) : ideal_reg;
    assign temper_eff = (temper_reg == '0) ? drt_pkg::TEMPER_W'(1) : temper_reg;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish_go = (state_reg == drt_pkg::ST_FINISH) && out_free;
    assign hist_push = finish_go;

    // ------------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hist_full ? drt_pkg::ST_SPAN : drt_pkg::ST_FINISH;
                end
            end
            drt_pkg::ST_SPAN:     state_next = drt_pkg::ST_DEV;
            drt_pkg::ST_DEV:      state_next = drt_pkg::ST_MAG_GO;
            drt_pkg::ST_MAG_GO:   state_next = drt_pkg::ST_MAG_WAIT;
            drt_pkg::ST_MAG_WAIT:
            begin
                if (div_done)
                begin
                    state_next = drt_pkg::ST_LO_GO;
                end
            end
            drt_pkg::ST_LO_GO:    state_next = drt_pkg::ST_LO_WAIT;
            drt_pkg::ST_LO_WAIT:
            begin
                if (div_done)
                begin
                    state_next = drt_pkg::ST_HI_GO;
                end
            end
            drt_pkg::ST_HI_GO:    state_next = drt_pkg::ST_HI_WAIT;
            drt_pkg::ST_HI_WAIT:
            begin
                if (div_done)
                begin
                    state_next = drt_pkg::ST_GOAL;
                end
            end
            drt_pkg::ST_GOAL:     state_next = drt_pkg::ST_CLAMP;
            drt_pkg::ST_CLAMP:    state_next = drt_pkg::ST_MUL_GO;
            drt_pkg::ST_MUL_GO:   state_next = drt_pkg::ST_MUL_WAIT;
            drt_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = drt_pkg::ST_QUO_GO;
                end
            end
            drt_pkg::ST_QUO_GO:   state_next = drt_pkg::ST_QUO_WAIT;
            drt_pkg::ST_QUO_WAIT:
            begin
                if (div_done)
                begin
                    state_next = drt_pkg::ST_FINISH;
                end
            end
            drt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = drt_pkg::ST_IDLE;
                end
            end
            default:              state_next = drt_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer outputs: input stall and unit operands
    // ------------------------------------------------------------------------
    assign dev_mag = dev_reg[drt_pkg::DEV_W-1] ? (~dev_reg + 1'b1) : dev_reg;

    always_comb
    begin
        in_stall      = 1'b1;
        div_req.start = 1'b0;
        div_req.steps = drt_pkg::DIV_CNT_W'(PW);
        div_dividend  = mul_prod;
        div_divisor   = ispan_reg;
        mul_start     = 1'b0;
        unique case (state_reg)
            drt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            drt_pkg::ST_MAG_GO, drt_pkg::ST_MAG_WAIT:
            begin
                div_req.start = (state_reg == drt_pkg::ST_MAG_GO);
                div_req.steps = drt_pkg::DIV_CNT_W'(drt_pkg::DEV_W);
                div_dividend  = {dev_mag, {(PW - drt_pkg::DEV_W){1'b0}}};
                div_divisor   = {{(SW - drt_pkg::TEMPER_W){1'b0}}, temper_eff};
            end
            drt_pkg::ST_LO_GO, drt_pkg::ST_LO_WAIT:
            begin
                div_req.start = (state_reg == drt_pkg::ST_LO_GO);
                div_req.steps = drt_pkg::DIV_CNT_W'(drt_pkg::P100_W);
                div_dividend  = {p100_reg, {(PW - drt_pkg::P100_W){1'b0}}};
                div_divisor   = SW'(drt_pkg::LO_DEN);
            end
            drt_pkg::ST_HI_GO, drt_pkg::ST_HI_WAIT:
            begin
                div_req.start = (state_reg == drt_pkg::ST_HI_GO);
                div_req.steps = drt_pkg::DIV_CNT_W'(drt_pkg::P100_W);
                div_dividend  = {p100_reg, {(PW - drt_pkg::P100_W){1'b0}}};
                div_divisor   = SW'(drt_pkg::HI_DEN);
            end
            drt_pkg::ST_MUL_GO:
            begin
                mul_start = 1'b1;
            end
            drt_pkg::ST_QUO_GO:
            begin
                div_req.start = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // Span, deviation and goal datapath
    // ------------------------------------------------------------------------
    assign win_prod  = WPROD_W'(ideal_eff) * WPROD_W'(WINDOW);
    assign ispan_ext = {{(drt_pkg::GOAL_W - SW){1'b0}}, ispan_reg};
    assign step_ext  = {{(drt_pkg::GOAL_W - drt_pkg::DEV_W){1'b0}}, step_reg};
    assign lo_ext    = {{(drt_pkg::GOAL_W - SW){1'b0}}, lo_reg};
    assign hi_ext    = {{(drt_pkg::GOAL_W - SW){1'b0}}, hi_reg};

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg  <= block_stamp;
            full_reg <= hist_full;
        end

        // Ideal span and actual span between the previous and oldest block.
        if (state_reg == drt_pkg::ST_SPAN)
        begin
            ispan_reg <= {win_prod, {drt_pkg::FRAC_W{1'b0}}};
            diff_reg  <= {1'b0, hist_prev} - {1'b0, hist_oldest};
        end

        // Deviation from the ideal span, and the ideal span scaled for bounds.
        if (state_reg == drt_pkg::ST_DEV)
        begin
            dev_reg  <= {diff_reg[drt_pkg::DIFF_W-1], diff_reg, {drt_pkg::FRAC_W{1'b0}}}
                        - {{(drt_pkg::DEV_W - SW){1'b0}}, ispan_reg};
            p100_reg <= drt_pkg::P100_W'(ispan_reg) * drt_pkg::P100_W'(drt_pkg::SCALE_NUM);
        end

        // Capture the serial divider results.
        if ((state_reg == drt_pkg::ST_MAG_WAIT) && div_done)
        begin
            step_reg <= div_quo[drt_pkg::DEV_W-1:0];
        end
        if ((state_reg == drt_pkg::ST_LO_WAIT) && div_done)
        begin
            lo_reg <= div_quo[SW-1:0];
        end
        if ((state_reg == drt_pkg::ST_HI_WAIT) && div_done)
        begin
            hi_reg <= div_quo[SW-1:0];
        end

        // Damped goal span, signed, before clamping.
        if (state_reg == drt_pkg::ST_GOAL)
        begin
            if (dev_reg[drt_pkg::DEV_W-1])
            begin
                goal_raw_reg <= ispan_ext - step_ext;
            end
            else
            begin
                goal_raw_reg <= ispan_ext + step_ext;
            end
        end

        // Clamp the goal between the two bounds.
        if (state_reg == drt_pkg::ST_CLAMP)
        begin
            if ($signed(goal_raw_reg) < $signed(lo_ext))
            begin
                goal_reg <= lo_reg;
            end
            else if ($signed(goal_raw_reg) > $signed(hi_ext))
            begin
                goal_reg <= hi_reg;
            end
            else
            begin
                goal_reg <= goal_raw_reg[SW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result: saturate the quotient, never let the target reach zero
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (div_quo[PW-1:TW] != '0)
        begin
            sat_target = '1;
        end
        else if (div_quo[TW-1:0] == '0)
        begin
            sat_target = TW'(1);
        end
        else
        begin
            sat_target = div_quo[TW-1:0];
        end
    end

    // The current target doubles as the output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            out_full_reg       <= 1'b0;
            current_target_reg <= drt_pkg::INITIAL_RESET;
        end
        else if (finish_go)
        begin
            out_valid_reg      <= 1'b1;
            out_full_reg       <= full_reg;
            current_target_reg <= full_reg ? sat_target : initial_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_target = current_target_reg;
    assign window_full = out_full_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The window state seen at acceptance holds until the history is pushed.
    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != drt_pkg::ST_IDLE) |-> (full_reg == hist_full))
        else $error("window state changed while a block is in flight");

    // The clamped goal lies between the bounds before it is multiplied.
    a_goal_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drt_pkg::ST_MUL_GO) |-> ((goal_reg >= lo_reg) && (goal_reg <= hi_reg)))
        else $error("goal span outside clamp bounds");

    // A retargeted result is never zero.
    a_target_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> (current_target_reg != '0))
        else $error("retargeted value is zero");

    // A new result word only appears out of the finish state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == drt_pkg::ST_FINISH))
        else $error("result word raised outside finish");

endmodule
